### rtl/core/ckc_pkg.sv
// ----------------------------------------------------------------------------
// ckc_pkg
// Shared types and constants of the canonical k-mer counter.
// ----------------------------------------------------------------------------
package ckc_pkg;

    localparam int MAX_K_DEF      = 8;
    localparam int COUNT_BITS_DEF = 32;

    localparam int KLEN_W      = 4;
    localparam int CHAR_W      = 8;
    localparam int IDX_W       = 16;
    localparam int COUNT_OUT_W = 32;
    localparam int RIDX_W      = 17;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 8;

    // request types
    localparam logic [1:0] REQ_BASE = 2'd0;
    localparam logic [1:0] REQ_EOS  = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANONICAL_MODE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BASE     = 8'd2;

    localparam logic [KLEN_W-1:0] KMER_LENGTH_RST = 4'd3;

    // ASCII bases and their 2-bit codes (lexicographic order)
    localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
    localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [CHAR_W-1:0] base_char;
        logic [IDX_W-1:0]  table_index;
        logic              read_clears;
    } req_word_t;

    typedef struct packed {
        logic [COUNT_OUT_W-1:0] count_value;
        logic [RIDX_W-1:0]      reported_index;
    } rsp_word_t;

    // table operation handed from the front end to the count table
    typedef struct packed {
        logic             op_count;
        logic             op_read;
        logic             read_clears;
        logic [IDX_W-1:0] table_index;
    } tbl_ctl_t;

endpackage

### rtl/core/ckc_kmer_window.sv
// ----------------------------------------------------------------------------
// ckc_kmer_window
// Forward and reverse-complement windows, run length and canonical key.
// ----------------------------------------------------------------------------
module ckc_kmer_window #(
    parameter int MAX_K = ckc_pkg::MAX_K_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic                        restart,
    input  logic [ckc_pkg::CHAR_W-1:0]  base_char,
    input  logic [ckc_pkg::KLEN_W-1:0]  kmer_length,
    input  logic                        canonical_mode,
    output logic                        hit,
    output logic [2*MAX_K-1:0]          key
);

    localparam int WIN_W = 2 * MAX_K;
    localparam int SH_W  = ckc_pkg::KLEN_W + 1;

    logic [WIN_W-1:0]           fwd_reg, fwd_next;
    logic [WIN_W-1:0]           rc_reg, rc_next;
    logic [ckc_pkg::KLEN_W-1:0] run_reg, run_next;

    logic [ckc_pkg::KLEN_W-1:0] k_eff;
    logic [1:0]                 code;
    logic                       code_ok;
    logic [WIN_W-1:0]           mask;
    logic [SH_W-1:0]            top_sh;
    logic [WIN_W-1:0]           fwd_shift;
    logic [WIN_W-1:0]           rc_shift;
    logic [ckc_pkg::KLEN_W-1:0] run_inc;

    always_comb
    begin
        if (kmer_length == '0)
            k_eff = ckc_pkg::KLEN_W'(1);
        else if (kmer_length > ckc_pkg::KLEN_W'(MAX_K))
            k_eff = ckc_pkg::KLEN_W'(MAX_K);
        else
            k_eff = kmer_length;
    end

    always_comb
    begin
        code_ok = 1'b1;
        unique case (base_char)
            ckc_pkg::CHAR_A: code = ckc_pkg::BASE_A;
            ckc_pkg::CHAR_C: code = ckc_pkg::BASE_C;
            ckc_pkg::CHAR_G: code = ckc_pkg::BASE_G;
            ckc_pkg::CHAR_T: code = ckc_pkg::BASE_T;
            default:
            begin
                code    = ckc_pkg::BASE_A;
                code_ok = 1'b0;
            end
        endcase
    end

    assign mask      = ~({WIN_W{1'b1}} << {k_eff, 1'b0});
    assign top_sh    = {k_eff, 1'b0} - SH_W'(2);
    assign fwd_shift = ((fwd_reg << 2) | WIN_W'(code)) & mask;
    assign rc_shift  = ((rc_reg >> 2) | (WIN_W'(2'd3 - code) << top_sh)) & mask;
    assign run_inc   = (run_reg < k_eff) ? run_reg + 1'b1 : run_reg;

    // a k-mer is complete once the run holds k valid bases
    assign hit = step && code_ok && (run_inc >= k_eff);
    assign key = (canonical_mode && (rc_shift < fwd_shift)) ? rc_shift : fwd_shift;

    always_comb
    begin
        fwd_next = fwd_reg;
        rc_next  = rc_reg;
        run_next = run_reg;
        if (restart)
        begin
            fwd_next = '0;
            rc_next  = '0;
            run_next = '0;
        end
        else if (step)
        begin
            if (code_ok)
            begin
                fwd_next = fwd_shift;
                rc_next  = rc_shift;
                run_next = run_inc;
            end
            else
            begin
                run_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= '0;
            rc_reg  <= '0;
            run_reg <= '0;
        end
        else
        begin
            fwd_reg <= fwd_next;
            rc_reg  <= rc_next;
            run_reg <= run_next;
        end
    end

endmodule

### rtl/core/ckc_count_table.sv
// ----------------------------------------------------------------------------
// ckc_count_table
// Count memory with read-modify-write, write forwarding and clear sweep.
// ----------------------------------------------------------------------------
module ckc_count_table #(
    parameter int MAX_K      = ckc_pkg::MAX_K_DEF,
    parameter int COUNT_BITS = ckc_pkg::COUNT_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ckc_pkg::tbl_ctl_t    op,
    input  logic [2*MAX_K-1:0]   op_addr,
    input  logic                 index_base,
    output logic                 busy,
    output logic                 res_valid,
    output ckc_pkg::rsp_word_t   res
);

    localparam int ADDR_W = 2 * MAX_K;
    localparam int DEPTH  = 1 << ADDR_W;

    logic [COUNT_BITS-1:0] mem [DEPTH];

    logic                  clear_reg, clear_next;
    logic [ADDR_W-1:0]     clear_addr_reg, clear_addr_next;

    ckc_pkg::tbl_ctl_t     s1_reg;
    logic [ADDR_W-1:0]     s1_addr_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;

    logic                  last_wr_valid_reg;
    logic [ADDR_W-1:0]     last_wr_addr_reg;
    logic [COUNT_BITS-1:0] last_wr_data_reg;

    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] inc;
    logic                  item_wr;
    logic [COUNT_BITS-1:0] item_data;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [COUNT_BITS-1:0] wr_data;

    // the write landing at the same edge as our read is not in rd_data_reg
    assign cur = (last_wr_valid_reg && (last_wr_addr_reg == s1_addr_reg))
                 ? last_wr_data_reg : rd_data_reg;
    assign inc = (cur == {COUNT_BITS{1'b1}}) ? cur : cur + 1'b1;

    assign item_wr   = s1_reg.op_count || (s1_reg.op_read && s1_reg.read_clears);
    assign item_data = s1_reg.op_count ? inc : '0;

    assign wr_en   = clear_reg || item_wr;
    assign wr_addr = clear_reg ? clear_addr_reg : s1_addr_reg;
    assign wr_data = clear_reg ? '0 : item_data;

    assign busy      = clear_reg;
    assign res_valid = s1_reg.op_read;
    assign res.count_value    = ckc_pkg::COUNT_OUT_W'(cur);
    assign res.reported_index = ckc_pkg::RIDX_W'(s1_reg.table_index)
                              + ckc_pkg::RIDX_W'(index_base);

    always_comb
    begin
        clear_next      = clear_reg;
        clear_addr_next = clear_addr_reg;
        if (clear_reg)
        begin
            clear_addr_next = clear_addr_reg + 1'b1;
            if (clear_addr_reg == {ADDR_W{1'b1}})
                clear_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[op_addr];
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg         <= 1'b1;
            clear_addr_reg    <= '0;
            s1_reg            <= '0;
            last_wr_valid_reg <= 1'b0;
        end
        else
        begin
            clear_reg         <= clear_next;
            clear_addr_reg    <= clear_addr_next;
            s1_reg            <= op;
            last_wr_valid_reg <= item_wr;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg      <= op_addr;
        last_wr_addr_reg <= s1_addr_reg;
        last_wr_data_reg <= item_data;
    end

endmodule

### rtl/core/canonical_kmer_counter.sv
// ----------------------------------------------------------------------------
// canonical_kmer_counter
// Streams DNA bases and counts canonical k-mers in a saturating table.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_stall/req): one word per cycle. A base word
// shifts the k-mer windows and, once k valid bases are in the run, bumps the
// count of the chosen k-mer; an end-of-sequence word restarts the windows; a
// read word returns one table entry, optionally zeroing it.
// Response channel (rsp_valid/rsp_stall/rsp): one word per read request, in
// request order, rsp_valid rising at the clock edge after the read is accepted.
// Throughput is one word per cycle: the table memory does one read and one
// write each cycle, and a count that hits the entry written in the previous
// cycle takes the forwarded value.
// Reset: after rst_n releases, a sweep zeroes the table, one entry per cycle,
// 4^MAX_K cycles (65536 at the default); req_stall stays high until it ends.
// The configuration port (cfg_valid/cfg_ready) always takes writes.
// A stalled response sits in a two-word output queue; req_stall rises only
// when another read could not find room in it.
// ----------------------------------------------------------------------------
module canonical_kmer_counter #(
    parameter int MAX_K      = ckc_pkg::MAX_K_DEF,
    parameter int COUNT_BITS = ckc_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ckc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ckc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  ckc_pkg::req_word_t              req,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output ckc_pkg::rsp_word_t              rsp
);

    localparam int ADDR_W = 2 * MAX_K;

    logic [ckc_pkg::KLEN_W-1:0] kmer_length_reg, kmer_length_next;
    logic                       canonical_mode_reg, canonical_mode_next;
    logic                       index_base_reg, index_base_next;

    logic                       cfg_wr;
    logic                       cfg_restart;
    logic                       accept;
    logic                       is_base;
    logic                       is_eos;
    logic                       is_read;
    logic                       hit;
    logic [ADDR_W-1:0]          key;
    logic [ADDR_W-1:0]          op_addr;
    ckc_pkg::tbl_ctl_t          op;
    logic                       busy;
    logic                       res_valid;
    ckc_pkg::rsp_word_t         res;

    ckc_pkg::rsp_word_t         q_reg [2];
    logic                       wr_ptr_reg;
    logic                       rd_ptr_reg;
    logic [1:0]                 cnt_reg, cnt_next;
    logic                       pop;
    logic [2:0]                 pending;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb
    begin
        kmer_length_next    = kmer_length_reg;
        canonical_mode_next = canonical_mode_reg;
        index_base_next     = index_base_reg;
        cfg_restart         = 1'b0;
        if (cfg_wr)
        begin
            unique case (cfg_index)
                ckc_pkg::CFG_KMER_LENGTH:
                begin
                    kmer_length_next = cfg_data[ckc_pkg::KLEN_W-1:0];
                    cfg_restart      = 1'b1;
                end
                ckc_pkg::CFG_CANONICAL_MODE: canonical_mode_next = cfg_data[0];
                ckc_pkg::CFG_INDEX_BASE:     index_base_next     = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_length_reg    <= ckc_pkg::KMER_LENGTH_RST;
            canonical_mode_reg <= 1'b1;
            index_base_reg     <= 1'b1;
        end
        else
        begin
            kmer_length_reg    <= kmer_length_next;
            canonical_mode_reg <= canonical_mode_next;
            index_base_reg     <= index_base_next;
        end
    end

    // ---------------- request side ----------------
    assign pop = rsp_valid && !rsp_stall;
    // results already owed to the queue once this edge has passed
    assign pending   = 3'(cnt_reg) - 3'(pop) + 3'(res_valid);
    assign req_stall = busy || (pending >= 3'd2);
    assign accept    = req_valid && !req_stall;

    assign is_base = accept && (req.req_type == ckc_pkg::REQ_BASE);
    assign is_eos  = accept && (req.req_type == ckc_pkg::REQ_EOS);
    assign is_read = accept && (req.req_type == ckc_pkg::REQ_READ);

    ckc_kmer_window #(
        .MAX_K (MAX_K)
    ) u_window (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (is_base),
        .restart        (is_eos || cfg_restart),
        .base_char      (req.base_char),
        .kmer_length    (kmer_length_reg),
        .canonical_mode (canonical_mode_reg),
        .hit            (hit),
        .key            (key)
    );

    assign op.op_count    = hit;
    assign op.op_read     = is_read;
    assign op.read_clears = req.read_clears;
    assign op.table_index = req.table_index;
    assign op_addr        = is_read ? ADDR_W'(req.table_index) : key;

    ckc_count_table #(
        .MAX_K      (MAX_K),
        .COUNT_BITS (COUNT_BITS)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .op_addr    (op_addr),
        .index_base (index_base_reg),
        .busy       (busy),
        .res_valid  (res_valid),
        .res        (res)
    );

    // ---------------- response queue ----------------
    assign rsp_valid = (cnt_reg != 2'd0);
    assign rsp       = q_reg[rd_ptr_reg];
    assign cnt_next  = cnt_reg + 2'(res_valid) - 2'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (res_valid)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            q_reg[wr_ptr_reg] <= res;
    end

endmodule

### sim/tb_canonical_kmer_counter.sv
// ----------------------------------------------------------------------------
// tb_canonical_kmer_counter
// Self-checking bench: drives base, end-of-sequence, read and unused-type words,
// keeps its own k-mer windows and count table, and checks every read word in order.
// ----------------------------------------------------------------------------
module tb_canonical_kmer_counter;

    localparam int MAX_K          = ckc_pkg::MAX_K_DEF;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 262144;   // covers the 4^MAX_K clearing sweep
    localparam int REPORT_LIMIT   = 10;

    localparam logic [1:0]                    REQ_UNUSED     = 2'd3;
    localparam logic [ckc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'd3;
    localparam logic [ckc_pkg::CFG_IDX_W-1:0] CFG_TOP_IDX    = 8'hFF;
    localparam logic [ckc_pkg::CHAR_W-1:0]    CHAR_LOWER_A   = 8'h61;
    localparam logic [ckc_pkg::CHAR_W-1:0]    CHAR_N         = 8'h4E;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [ckc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ckc_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           req_valid;
    logic                           req_stall;
    ckc_pkg::req_word_t             req;
    logic                           rsp_valid;
    logic                           rsp_stall;
    ckc_pkg::rsp_word_t             rsp;

    canonical_kmer_counter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // predicted block state
    bit   [31:0]                kmer_count [65536];
    logic [15:0]                fwd_window   = '0;
    logic [15:0]                rc_window    = '0;
    int unsigned                run_len      = 0;
    logic [ckc_pkg::KLEN_W-1:0] kmer_len_reg = ckc_pkg::KMER_LENGTH_RST;
    logic                       canon_reg    = 1'b1;
    logic                       ibase_reg    = 1'b1;
    logic [15:0]                last_kmer    = '0;

    ckc_pkg::rsp_word_t expected_counts [$];

    int err_count      = 0;
    int quiet_cycles   = 0;
    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int hold_request   = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned eff_k();
        if (kmer_len_reg == 0)
            return 1;
        if (kmer_len_reg > MAX_K)
            return MAX_K;
        return kmer_len_reg;
    endfunction

    function automatic void restart_windows();
        fwd_window = '0;
        rc_window  = '0;
        run_len    = 0;
    endfunction

    function automatic void update_kmer_counts(input ckc_pkg::req_word_t w);
        int unsigned        k;
        logic [15:0]        mask;
        logic [15:0]        comp;
        logic [15:0]        key;
        logic [1:0]         code;
        bit                 is_base;
        ckc_pkg::rsp_word_t r;
        k = eff_k();
        case (w.req_type)
            ckc_pkg::REQ_BASE:
            begin
                is_base = 1'b1;
                code    = ckc_pkg::BASE_A;
                case (w.base_char)
                    ckc_pkg::CHAR_A: code = ckc_pkg::BASE_A;
                    ckc_pkg::CHAR_C: code = ckc_pkg::BASE_C;
                    ckc_pkg::CHAR_G: code = ckc_pkg::BASE_G;
                    ckc_pkg::CHAR_T: code = ckc_pkg::BASE_T;
                    default:         is_base = 1'b0;
                endcase
                if (!is_base)
                    run_len = 0;
                else
                begin
                    mask       = 16'((32'd1 << (2 * k)) - 1);
                    comp       = 16'd3 - 16'(code);
                    fwd_window = ((fwd_window << 2) | 16'(code)) & mask;
                    rc_window  = ((rc_window >> 2) | (comp << (2 * (k - 1)))) & mask;
                    if (run_len < k)
                        run_len++;
                    if (run_len >= k)
                    begin
                        key = fwd_window;
                        if (canon_reg && rc_window < key)
                            key = rc_window;
                        last_kmer = key;
                        if (kmer_count[key] != '1)
                            kmer_count[key] = kmer_count[key] + 1;
                    end
                end
            end
            ckc_pkg::REQ_EOS:
                restart_windows();
            ckc_pkg::REQ_READ:
            begin
                r.count_value    = kmer_count[w.table_index];
                r.reported_index = {1'b0, w.table_index} + ckc_pkg::RIDX_W'(ibase_reg);
                expected_counts.insert(expected_counts.size(), r);
                if (w.read_clears)
                    kmer_count[w.table_index] = '0;
            end
            default: ;
        endcase
    endfunction

    function automatic ckc_pkg::req_word_t mk_word(input logic [1:0] t,
                                                   input logic [ckc_pkg::CHAR_W-1:0] ch,
                                                   input logic [ckc_pkg::IDX_W-1:0] idx,
                                                   input logic clr);
        ckc_pkg::req_word_t w;
        w.req_type    = t;
        w.base_char   = ch;
        w.table_index = idx;
        w.read_clears = clr;
        return w;
    endfunction

    // mostly clean base runs, with some reads aimed at the k-mer that was counted last
    function automatic ckc_pkg::req_word_t rand_word();
        ckc_pkg::req_word_t w;
        int unsigned        pick;
        int unsigned        aim;
        w = mk_word(ckc_pkg::REQ_BASE, 8'($urandom), 16'($urandom), 1'($urandom));
        pick = $urandom_range(99);
        if (pick < 62)
        begin
            case ($urandom_range(3))
                0:       w.base_char = ckc_pkg::CHAR_A;
                1:       w.base_char = ckc_pkg::CHAR_C;
                2:       w.base_char = ckc_pkg::CHAR_G;
                default: w.base_char = ckc_pkg::CHAR_T;
            endcase
        end
        else if (pick < 67)
            w.req_type = ckc_pkg::REQ_BASE;
        else if (pick < 71)
            w.req_type = ckc_pkg::REQ_EOS;
        else if (pick < 97)
        begin
            w.req_type    = ckc_pkg::REQ_READ;
            w.read_clears = ($urandom_range(3) == 0);
            aim = $urandom_range(9);
            if (aim < 4)
                w.table_index = last_kmer;
            else if (aim < 8)
                w.table_index = 16'($urandom_range((32'd1 << (2 * eff_k())) - 1));
        end
        else
            w.req_type = REQ_UNUSED;
        return w;
    endfunction

    task automatic send_word(input ckc_pkg::req_word_t w);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        do
            @(posedge clk);
        while (req_stall);
        update_kmer_counts(w);
    endtask

    task automatic write_reg(input logic [ckc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ckc_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            ckc_pkg::CFG_KMER_LENGTH:
            begin
                kmer_len_reg = val[ckc_pkg::KLEN_W-1:0];
                restart_windows();
            end
            ckc_pkg::CFG_CANONICAL_MODE: canon_reg = val[0];
            ckc_pkg::CFG_INDEX_BASE:     ibase_reg = val[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait for every read word, then let base words still in flight retire
    task automatic drain();
        req_valid <= 1'b0;
        while (expected_counts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed_stream();
        send_idle_pct = 0;
        stall_pct     = 0;
        // at k=3, ACG and CGT share one canonical code
        send_word(mk_word(ckc_pkg::REQ_BASE, ckc_pkg::CHAR_A, 16'h0000, 1'b0));
        send_word(mk_word(ckc_pkg::REQ_BASE, ckc_pkg::CHAR_C, 16'hFFFF, 1'b1));
        send_word(mk_word(ckc_pkg::REQ_BASE, ckc_pkg::CHAR_G, 16'h0000, 1'b0));
        send_word(mk_word(ckc_pkg::REQ_BASE, ckc_pkg::CHAR_T, 16'h0000, 1'b0));
        send_word(mk_word(ckc_pkg::REQ_BASE, CHAR_LOWER_A, 16'h0000, 1'b0));
        send_word(mk_word(ckc_pkg::REQ_BASE, ckc_pkg::CHAR_G, 16'h0000, 1'b0));
        send_word(mk_word(ckc_pkg::REQ_BASE, ckc_pkg::CHAR_T, 16'h0000, 1'b0));
        send_word(mk_word(ckc_pkg::REQ_BASE, CHAR_N, 16'h0000, 1'b0));
        send_word(mk_word(ckc_pkg::REQ_BASE, ckc_pkg::CHAR_T, 16'h0000, 1'b0));
        send_word(mk_word(ckc_pkg::REQ_BASE, ckc_pkg::CHAR_T, 16'h0000, 1'b0));
        send_word(mk_word(ckc_pkg::REQ_BASE, ckc_pkg::CHAR_T, 16'h0000, 1'b0));
        send_word(mk_word(ckc_pkg::REQ_BASE, 8'h00, 16'h0000, 1'b0));
        send_word(mk_word(ckc_pkg::REQ_BASE, 8'hFF, 16'h0000, 1'b0));
        send_word(mk_word(ckc_pkg::REQ_BASE, ckc_pkg::CHAR_A, 16'h0000, 1'b0));
        send_word(mk_word(ckc_pkg::REQ_EOS, 8'hFF, 16'hFFFF, 1'b1));
        send_word(mk_word(ckc_pkg::REQ_BASE, ckc_pkg::CHAR_C, 16'h0000, 1'b0));
        send_word(mk_word(REQ_UNUSED, 8'hFF, 16'hFFFF, 1'b1));
        send_word(mk_word(ckc_pkg::REQ_READ, 8'h00, 16'd6, 1'b1));
        send_word(mk_word(ckc_pkg::REQ_READ, 8'hFF, 16'd6, 1'b0));
        send_word(mk_word(ckc_pkg::REQ_READ, 8'h00, 16'd0, 1'b0));
        send_word(mk_word(ckc_pkg::REQ_READ, 8'h00, 16'd63, 1'b0));
        send_word(mk_word(ckc_pkg::REQ_READ, 8'hFF, 16'hFFFF, 1'b1));
        drain();
    endtask

    task automatic test_register_effects();
        // writes past the register list are dropped
        write_reg(CFG_UNUSED_IDX, 8'hFF);
        write_reg(CFG_TOP_IDX, 8'h00);
        // rewriting k mid-run restarts the window: no k-mer spans the write
        send_word(mk_word(ckc_pkg::REQ_BASE, ckc_pkg::CHAR_A, 16'h0000, 1'b0));
        send_word(mk_word(ckc_pkg::REQ_BASE, ckc_pkg::CHAR_C, 16'h0000, 1'b0));
        drain();
        write_reg(ckc_pkg::CFG_KMER_LENGTH, 8'hF3);
        send_word(mk_word(ckc_pkg::REQ_BASE, ckc_pkg::CHAR_G, 16'h0000, 1'b0));
        send_word(mk_word(ckc_pkg::REQ_READ, 8'h00, 16'd6, 1'b0));
        drain();
    endtask

    task automatic test_random_phases();
        logic [7:0]         klen_data  [6] = '{8'h03, 8'h00, 8'hFF, 8'h01, 8'h08, 8'h05};
        logic [7:0]         canon_data [6] = '{8'h01, 8'hFE, 8'hFF, 8'h00, 8'h01, 8'h01};
        logic [7:0]         base_data  [6] = '{8'h01, 8'h00, 8'hFF, 8'h02, 8'h01, 8'h00};
        int                 idle_pcts  [6] = '{0, 75, 0, 31, 31, 0};
        int                 stall_pcts [6] = '{0, 0, 75, 31, 31, 0};
        int                 words      [6] = '{200, 150, 200, 150, 150, 150};
        int                 sent;
        ckc_pkg::req_word_t w;
        for (int p = 0; p < 6; p++)
        begin
            write_reg(ckc_pkg::CFG_KMER_LENGTH, klen_data[p]);
            write_reg(ckc_pkg::CFG_CANONICAL_MODE, canon_data[p]);
            write_reg(ckc_pkg::CFG_INDEX_BASE, base_data[p]);
            send_idle_pct = idle_pcts[p];
            stall_pct     = stall_pcts[p];
            sent = 0;
            while (sent < words[p])
            begin
                w = rand_word();
                send_word(w);
                if (w.req_type != REQ_UNUSED)
                    sent++;
            end
            drain();
        end
    endtask

    // long receiver hold-off while reads keep coming, so the input backs up
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = 200;
        repeat (40)
            send_word(mk_word(ckc_pkg::REQ_READ, 8'($urandom),
                              16'($urandom_range(63)), 1'b0));
        drain();
    endtask

    initial
    begin : receiver
        int held;
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                held         = hold_request;
                hold_request = 0;
                rsp_stall   <= 1'b1;
                repeat (held) @(posedge clk);
            end
            rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
        end
    end

    function automatic void note_error(input string msg);
        err_count++;
        if (err_count <= REPORT_LIMIT)
            $display("ERROR: %s", msg);
    endfunction

    always @(posedge clk)
    begin : check_counts
        ckc_pkg::rsp_word_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_counts.size() == 0)
                note_error($sformatf("unexpected word count=%0d index=%0d",
                                     rsp.count_value, rsp.reported_index));
            else
            begin
                want = expected_counts.pop_front();
                if (rsp.count_value !== want.count_value)
                    note_error($sformatf("count_value exp=%0d got=%0d (index %0d)",
                                         want.count_value, rsp.count_value,
                                         want.reported_index));
                if (rsp.reported_index !== want.reported_index)
                    note_error($sformatf("reported_index exp=%0d got=%0d",
                                         want.reported_index, rsp.reported_index));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_stream();
        test_register_effects();
        test_random_phases();
        test_output_backpressure();
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### sim.f
rtl/core/ckc_pkg.sv
rtl/core/ckc_kmer_window.sv
rtl/core/ckc_count_table.sv
rtl/core/canonical_kmer_counter.sv
sim/tb_canonical_kmer_counter.sv
